// ===== hdl/dvpd_pkg.sv =====
package dvpd_pkg;

  localparam int FRAME_W    = 49;
  localparam int KEY_W      = 48;
  localparam int EKEY_W     = 40;
  localparam int ID_W       = 8;
  localparam int BKEY_W     = 8;
  localparam int ROM_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  localparam logic [ID_W-1:0] FID_BASIC = 8'h10;
  localparam logic [ID_W-1:0] FID_ENH   = 8'h68;

  localparam logic [ROM_W-1:0] BASIC_HI_MASK = 16'hFF0F;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_BASIC_KEY    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENHANCED_KEY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_SLOT0   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_SLOT1   = 8'd3;

  typedef enum logic [1:0] {
    CIPHER_NONE  = 2'd0,
    CIPHER_BASIC = 2'd1,
    CIPHER_ENH   = 2'd2
  } cipher_t;

  typedef struct packed {
    logic               slot;
    logic [FRAME_W-1:0] voice_bits;
    logic               privacy_flag;
    logic [ID_W-1:0]    key_id;
    logic [ID_W-1:0]    feature_id;
    logic               new_call;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] clear_bits;
    cipher_t            cipher;
    logic               encrypted;
    logic               play;
  } result_t;

  // rolling key write-back for the frame's slot
  typedef struct packed {
    logic             upd;
    logic [KEY_W-1:0] key;
  } key_upd_t;

  typedef struct packed {
    logic [BKEY_W-1:0] basic_key;
    logic [EKEY_W-1:0] enhanced_key;
    logic              mute_slot0;
    logic              mute_slot1;
  } cfg_t;

  localparam logic [ROM_W-1:0] BP_ROM [256] = '{
    16'h0000, 16'h1F00, 16'hE300, 16'hFC00, 16'h2503, 16'h3A03, 16'hC603, 16'hD903,
    16'h4A05, 16'h5505, 16'hA905, 16'hB605, 16'h6F06, 16'h7006, 16'h8C06, 16'h9306,
    16'h2618, 16'h3918, 16'hC518, 16'hDA18, 16'h031B, 16'h1C1B, 16'hE01B, 16'hFF1B,
    16'h6C1D, 16'h731D, 16'h8F1D, 16'h901D, 16'h491E, 16'h561E, 16'hAA1E, 16'hB51E,
    16'h4B28, 16'h5428, 16'hA828, 16'hB728, 16'h6E2B, 16'h712B, 16'h8D2B, 16'h922B,
    16'h012D, 16'h1E2D, 16'hE22D, 16'hFD2D, 16'h242E, 16'h3B2E, 16'hC72E, 16'hD82E,
    16'h6D30, 16'h7230, 16'h8E30, 16'h9130, 16'h4833, 16'h5733, 16'hAB33, 16'hB433,
    16'h2735, 16'h3835, 16'hC435, 16'hDB35, 16'h0236, 16'h1D36, 16'hE136, 16'hFE36,
    16'h2B49, 16'h3449, 16'hC849, 16'hD749, 16'h0E4A, 16'h114A, 16'hED4A, 16'hF24A,
    16'h614C, 16'hAE4C, 16'h824C, 16'h9D4C, 16'h444F, 16'h5B4F, 16'hA74F, 16'hB84F,
    16'h0D51, 16'h1251, 16'hEE51, 16'hF151, 16'h2852, 16'h3752, 16'hCB52, 16'hD452,
    16'h4754, 16'h5854, 16'hA454, 16'hBB54, 16'h6257, 16'h7D57, 16'h8157, 16'h9E57,
    16'h6061, 16'h7F61, 16'h8361, 16'h9C61, 16'h4562, 16'h5A62, 16'hA662, 16'hB962,
    16'h2A64, 16'h3564, 16'hC964, 16'hD664, 16'h0F67, 16'h1067, 16'hEC67, 16'hF367,
    16'h4679, 16'h5979, 16'hA579, 16'hBA79, 16'h637A, 16'h7C7A, 16'h807A, 16'h9F7A,
    16'h0C7C, 16'h137C, 16'hEF7C, 16'hF07C, 16'h297F, 16'h367F, 16'hCA7F, 16'hD57F,
    16'h4D89, 16'h5289, 16'hAE89, 16'hB189, 16'h688A, 16'h778A, 16'h8B8A, 16'h948A,
    16'h078C, 16'h188C, 16'hE48C, 16'hFB8C, 16'h228F, 16'h3D8F, 16'hC18F, 16'hDE8F,
    16'h6B91, 16'h7491, 16'h8891, 16'h9791, 16'h4E92, 16'h5192, 16'hAD92, 16'hB292,
    16'h2194, 16'h3E94, 16'hC294, 16'hDD94, 16'h0497, 16'h1B97, 16'hE797, 16'hF897,
    16'h06A1, 16'h19A1, 16'hE5A1, 16'hFAA1, 16'h23A2, 16'h3CA2, 16'hC0A2, 16'hDFA2,
    16'h4CA4, 16'h53A4, 16'hAFA4, 16'hB0A4, 16'h69A7, 16'h76A7, 16'h8AA7, 16'h95A7,
    16'h20B9, 16'h3FB9, 16'hC3B9, 16'hDCB9, 16'h05BA, 16'h1ABA, 16'hE6BA, 16'hF9BA,
    16'h6ABC, 16'h75BC, 16'h89BC, 16'h96BC, 16'h4FBF, 16'h50BF, 16'hACBF, 16'hB3BF,
    16'h66C0, 16'h79C0, 16'h85C0, 16'h9AC0, 16'h43C3, 16'h5CC3, 16'hA0C3, 16'hBFC3,
    16'h2CC5, 16'h33C5, 16'hCFC5, 16'hD0C5, 16'h09C6, 16'h16C6, 16'hEAC6, 16'hF5C6,
    16'h84D0, 16'h85DF, 16'h8AD3, 16'h8BDC, 16'hB6D5, 16'hB7DA, 16'hB8D6, 16'hB9D9,
    16'hD0DA, 16'hD1D5, 16'hDED9, 16'hDFD6, 16'hE2DF, 16'hE3D0, 16'hECDC, 16'hEDD3,
    16'h2DE8, 16'h32E8, 16'hCEE8, 16'hD1E8, 16'h08EB, 16'h17EB, 16'hEBEB, 16'hF4EB,
    16'h67ED, 16'h78ED, 16'h84ED, 16'h9BED, 16'h42EE, 16'h5DEE, 16'hA1EE, 16'hBEEE,
    16'h0BF0, 16'h14F0, 16'hE8F0, 16'hF7F0, 16'h2EF3, 16'h31F3, 16'hCDF3, 16'hD2F3,
    16'h41F5, 16'h5EF5, 16'hA2F5, 16'hBDF5, 16'h64F6, 16'h7BF6, 16'h87F6, 16'h98F6
  };

  // keystream bit j is key bit 47-j
  function automatic logic [KEY_W-1:0] rev_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    for (int j = 0; j < KEY_W; j++) begin
      r[j] = k[KEY_W-1-j];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] basic_expand(input logic [ROM_W-1:0] e);
    return {e & BASIC_HI_MASK, e, e};
  endfunction

  // 40-bit key followed by a copy of its top byte
  function automatic logic [KEY_W-1:0] key_load(input logic [EKEY_W-1:0] ek);
    return {ek, ek[EKEY_W-1 -: 8]};
  endfunction

  // t = k << 1; k' = ((t << 8) & 0xFFFFFFFF0000) | ((t >> 32) & 0xFFFF)
  function automatic logic [KEY_W-1:0] key_advance(input logic [KEY_W-1:0] k);
    return {k[38:7], k[46:31]};
  endfunction

endpackage

// ===== hdl/dvpd_core.sv =====
module dvpd_core (
  input  dvpd_pkg::item_t                item,
  input  dvpd_pkg::cfg_t                 cfg,
  input  logic [dvpd_pkg::KEY_W-1:0]     roll_key,
  input  logic                           key_loaded,
  output dvpd_pkg::result_t              res,
  output dvpd_pkg::key_upd_t             kupd
);

  logic                          gate;
  logic                          use_basic;
  logic                          use_enh;
  logic [dvpd_pkg::KEY_W-1:0]    basic_key48;
  logic [dvpd_pkg::KEY_W-1:0]    enh_key48;
  logic [dvpd_pkg::KEY_W-1:0]    sel_key;
  logic                          mute;

  always_comb begin
    gate      = item.privacy_flag && (item.key_id == '0);
    use_basic = gate && (item.feature_id == dvpd_pkg::FID_BASIC) && (cfg.basic_key != '0);
    use_enh   = gate && !use_basic && (item.feature_id == dvpd_pkg::FID_ENH)
                && (cfg.enhanced_key != '0);

    basic_key48 = dvpd_pkg::basic_expand(dvpd_pkg::BP_ROM[cfg.basic_key]);
    // reload on the first frame of a call or if this slot never had a key
    enh_key48   = (item.new_call || !key_loaded) ? dvpd_pkg::key_load(cfg.enhanced_key)
                                                  : roll_key;

    sel_key = '0;
    res.cipher = dvpd_pkg::CIPHER_NONE;
    if (use_basic) begin
      sel_key    = basic_key48;
      res.cipher = dvpd_pkg::CIPHER_BASIC;
    end else if (use_enh) begin
      sel_key    = enh_key48;
      res.cipher = dvpd_pkg::CIPHER_ENH;
    end

    // top frame bit passes through
    res.clear_bits = item.voice_bits ^ {1'b0, dvpd_pkg::rev_key(sel_key)};
    res.encrypted  = item.privacy_flag;
    mute           = item.slot ? cfg.mute_slot1 : cfg.mute_slot0;
    res.play       = !item.privacy_flag || !mute;

    kupd.upd = use_enh;
    kupd.key = dvpd_pkg::key_advance(enh_key48);
  end

endmodule

// ===== hdl/dmr_voice_privacy_descrambler_unit.sv =====
// DMR voice privacy descrambler. Takes one FEC-decoded 49-bit voice frame per
// transfer and returns one result per frame, in order: the frame with basic
// privacy or enhanced rolling-key scrambling removed from bits 0..47, the
// cipher used, the encrypted flag and a play decision from the slot's mute
// register. Throughput is one frame per clock while the output is not
// stalled. A frame taken in goes to an input register, then to the result
// register, with the whole descramble and key-advance path between them.
// A stalled result register does not block one more frame from being taken
// into the input register. Each slot keeps its own rolling key, updated at
// the moment an enhanced frame moves into the result register, so frames of
// the same slot may follow each other back to back. Configuration is written
// through cfg_we/cfg_index/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce; unknown indexes
// are ignored.
module dmr_voice_privacy_descrambler_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [dvpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dvpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_slot,
  input  logic [dvpd_pkg::FRAME_W-1:0]      in_voice_bits,
  input  logic                              in_privacy_flag,
  input  logic [dvpd_pkg::ID_W-1:0]         in_key_id,
  input  logic [dvpd_pkg::ID_W-1:0]         in_feature_id,
  input  logic                              in_new_call,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dvpd_pkg::FRAME_W-1:0]      out_clear_bits,
  output logic [1:0]                        out_cipher_used,
  output logic                              out_encrypted,
  output logic                              out_play
);

  dvpd_pkg::cfg_t                cfg_r;
  dvpd_pkg::item_t               item_r;
  logic                          item_valid_r;
  dvpd_pkg::result_t             res_r;
  logic                          res_valid_r;
  logic [dvpd_pkg::KEY_W-1:0]    roll_key_r [2];
  logic [1:0]                    key_loaded_r;

  dvpd_pkg::result_t             res_nxt;
  dvpd_pkg::key_upd_t            kupd;
  logic                          advance;
  logic                          in_take;

  assign advance  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basic_key    <= '0;
      cfg_r.enhanced_key <= '0;
      cfg_r.mute_slot0   <= 1'b1;
      cfg_r.mute_slot1   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvpd_pkg::CFG_BASIC_KEY:    cfg_r.basic_key    <= cfg_wdata[dvpd_pkg::BKEY_W-1:0];
        dvpd_pkg::CFG_ENHANCED_KEY: cfg_r.enhanced_key <= cfg_wdata[dvpd_pkg::EKEY_W-1:0];
        dvpd_pkg::CFG_MUTE_SLOT0:   cfg_r.mute_slot0   <= cfg_wdata[0];
        dvpd_pkg::CFG_MUTE_SLOT1:   cfg_r.mute_slot1   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.slot         <= in_slot;
      item_r.voice_bits   <= in_voice_bits;
      item_r.privacy_flag <= in_privacy_flag;
      item_r.key_id       <= in_key_id;
      item_r.feature_id   <= in_feature_id;
      item_r.new_call     <= in_new_call;
    end
  end

  dvpd_core u_core (
    .item       (item_r),
    .cfg        (cfg_r),
    .roll_key   (roll_key_r[item_r.slot]),
    .key_loaded (key_loaded_r[item_r.slot]),
    .res        (res_nxt),
    .kupd       (kupd)
  );

  // per-slot rolling key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_loaded_r  <= '0;
      roll_key_r[0] <= '0;
      roll_key_r[1] <= '0;
    end else if (advance && kupd.upd) begin
      key_loaded_r[item_r.slot] <= 1'b1;
      roll_key_r[item_r.slot]   <= kupd.key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_clear_bits  = res_r.clear_bits;
  assign out_cipher_used = res_r.cipher;
  assign out_encrypted   = res_r.encrypted;
  assign out_play        = res_r.play;

endmodule

// ===== tb/dmr_voice_privacy_descrambler_unit_tb.sv =====
`timescale 1ns / 100ps

module dmr_voice_privacy_descrambler_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 9;
  localparam int PHASE_FRAMES = 205;
  localparam logic [dvpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'hFF;

  localparam logic [48:0] ALL_ONES = 49'h1_FFFF_FFFF_FFFF;
  localparam logic [39:0] EKEY_MAX = 40'hFF_FFFF_FFFF;

  // keystream ROM for basic privacy, indexed by the basic key
  localparam logic [15:0] PRIVACY_ROM [256] = '{
    16'h0000, 16'h1F00, 16'hE300, 16'hFC00, 16'h2503, 16'h3A03, 16'hC603, 16'hD903,
    16'h4A05, 16'h5505, 16'hA905, 16'hB605, 16'h6F06, 16'h7006, 16'h8C06, 16'h9306,
    16'h2618, 16'h3918, 16'hC518, 16'hDA18, 16'h031B, 16'h1C1B, 16'hE01B, 16'hFF1B,
    16'h6C1D, 16'h731D, 16'h8F1D, 16'h901D, 16'h491E, 16'h561E, 16'hAA1E, 16'hB51E,
    16'h4B28, 16'h5428, 16'hA828, 16'hB728, 16'h6E2B, 16'h712B, 16'h8D2B, 16'h922B,
    16'h012D, 16'h1E2D, 16'hE22D, 16'hFD2D, 16'h242E, 16'h3B2E, 16'hC72E, 16'hD82E,
    16'h6D30, 16'h7230, 16'h8E30, 16'h9130, 16'h4833, 16'h5733, 16'hAB33, 16'hB433,
    16'h2735, 16'h3835, 16'hC435, 16'hDB35, 16'h0236, 16'h1D36, 16'hE136, 16'hFE36,
    16'h2B49, 16'h3449, 16'hC849, 16'hD749, 16'h0E4A, 16'h114A, 16'hED4A, 16'hF24A,
    16'h614C, 16'hAE4C, 16'h824C, 16'h9D4C, 16'h444F, 16'h5B4F, 16'hA74F, 16'hB84F,
    16'h0D51, 16'h1251, 16'hEE51, 16'hF151, 16'h2852, 16'h3752, 16'hCB52, 16'hD452,
    16'h4754, 16'h5854, 16'hA454, 16'hBB54, 16'h6257, 16'h7D57, 16'h8157, 16'h9E57,
    16'h6061, 16'h7F61, 16'h8361, 16'h9C61, 16'h4562, 16'h5A62, 16'hA662, 16'hB962,
    16'h2A64, 16'h3564, 16'hC964, 16'hD664, 16'h0F67, 16'h1067, 16'hEC67, 16'hF367,
    16'h4679, 16'h5979, 16'hA579, 16'hBA79, 16'h637A, 16'h7C7A, 16'h807A, 16'h9F7A,
    16'h0C7C, 16'h137C, 16'hEF7C, 16'hF07C, 16'h297F, 16'h367F, 16'hCA7F, 16'hD57F,
    16'h4D89, 16'h5289, 16'hAE89, 16'hB189, 16'h688A, 16'h778A, 16'h8B8A, 16'h948A,
    16'h078C, 16'h188C, 16'hE48C, 16'hFB8C, 16'h228F, 16'h3D8F, 16'hC18F, 16'hDE8F,
    16'h6B91, 16'h7491, 16'h8891, 16'h9791, 16'h4E92, 16'h5192, 16'hAD92, 16'hB292,
    16'h2194, 16'h3E94, 16'hC294, 16'hDD94, 16'h0497, 16'h1B97, 16'hE797, 16'hF897,
    16'h06A1, 16'h19A1, 16'hE5A1, 16'hFAA1, 16'h23A2, 16'h3CA2, 16'hC0A2, 16'hDFA2,
    16'h4CA4, 16'h53A4, 16'hAFA4, 16'hB0A4, 16'h69A7, 16'h76A7, 16'h8AA7, 16'h95A7,
    16'h20B9, 16'h3FB9, 16'hC3B9, 16'hDCB9, 16'h05BA, 16'h1ABA, 16'hE6BA, 16'hF9BA,
    16'h6ABC, 16'h75BC, 16'h89BC, 16'h96BC, 16'h4FBF, 16'h50BF, 16'hACBF, 16'hB3BF,
    16'h66C0, 16'h79C0, 16'h85C0, 16'h9AC0, 16'h43C3, 16'h5CC3, 16'hA0C3, 16'hBFC3,
    16'h2CC5, 16'h33C5, 16'hCFC5, 16'hD0C5, 16'h09C6, 16'h16C6, 16'hEAC6, 16'hF5C6,
    16'h84D0, 16'h85DF, 16'h8AD3, 16'h8BDC, 16'hB6D5, 16'hB7DA, 16'hB8D6, 16'hB9D9,
    16'hD0DA, 16'hD1D5, 16'hDED9, 16'hDFD6, 16'hE2DF, 16'hE3D0, 16'hECDC, 16'hEDD3,
    16'h2DE8, 16'h32E8, 16'hCEE8, 16'hD1E8, 16'h08EB, 16'h17EB, 16'hEBEB, 16'hF4EB,
    16'h67ED, 16'h78ED, 16'h84ED, 16'h9BED, 16'h42EE, 16'h5DEE, 16'hA1EE, 16'hBEEE,
    16'h0BF0, 16'h14F0, 16'hE8F0, 16'hF7F0, 16'h2EF3, 16'h31F3, 16'hCDF3, 16'hD2F3,
    16'h41F5, 16'h5EF5, 16'hA2F5, 16'hBDF5, 16'h64F6, 16'h7BF6, 16'h87F6, 16'h98F6
  };

  typedef enum logic [1:0] {
    ROW_CFG   = 2'd0,  // register write, block drained first
    ROW_PRED  = 2'd1,  // frame checked against the predictor
    ROW_FIXED = 2'd2   // clear frame: voice bits and flag pass straight through
  } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [dvpd_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [48:0]                      data;
    logic                             slot;
    logic                             priv;
    logic [7:0]                       key_id;
    logic [7:0]                       feat_id;
    logic                             new_call;
    dvpd_pkg::cipher_t                x_cipher;
    logic                             x_play;
  } row_t;

  localparam int NUM_ROWS = 35;
  localparam row_t PLAN [NUM_ROWS] = '{
    // reset config: both ciphers disabled, both slots muted
    '{ROW_FIXED, '0, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b1},
    '{ROW_FIXED, '0, ALL_ONES, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_FIXED, '0, 49'h0_AAAA_AAAA_AAAA, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_FIXED, '0, 49'h1_5555_5555_5555, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_BASIC_KEY, 49'h1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_ENHANCED_KEY, 49'(EKEY_MAX), 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT0, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT1, 49'h1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h0, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, ALL_ONES, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    // nonzero key id leaves the frame clear
    '{ROW_FIXED, '0, 49'h0_AAAA_AAAA_AAAA, 1'b0, 1'b1, 8'h01, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b1},
    // first enhanced frame loads the key even without new_call
    '{ROW_PRED, '0, 49'h0, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, ALL_ONES, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h0, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, ALL_ONES, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h1_5555_5555_5555, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_FIXED, '0, 49'h0_AAAA_AAAA_AAAA, 1'b0, 1'b0, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b1},
    '{ROW_CFG, dvpd_pkg::CFG_BASIC_KEY, 49'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_ENHANCED_KEY, 49'h1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT0, 49'h1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT1, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, CFG_SPARE, ALL_ONES, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, ALL_ONES, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h0, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    // loaded rolling keys survive the key register write
    '{ROW_PRED, '0, 49'h0, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, ALL_ONES, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h0, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_PRED, '0, 49'h0_AAAA_AAAA_AAAA, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_BASIC_KEY, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_ENHANCED_KEY, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT0, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_CFG, dvpd_pkg::CFG_MUTE_SLOT1, 49'h0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b0},
    '{ROW_FIXED, '0, ALL_ONES, 1'b0, 1'b1, 8'h00, dvpd_pkg::FID_BASIC, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b1},
    '{ROW_FIXED, '0, 49'h0_AAAA_AAAA_AAAA, 1'b1, 1'b1, 8'h00, dvpd_pkg::FID_ENH, 1'b1,
      dvpd_pkg::CIPHER_NONE, 1'b1},
    '{ROW_FIXED, '0, 49'h1_5555_5555_5555, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0,
      dvpd_pkg::CIPHER_NONE, 1'b1}
  };

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [dvpd_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [dvpd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_slot;
  logic [dvpd_pkg::FRAME_W-1:0]     in_voice_bits;
  logic                             in_privacy_flag;
  logic [dvpd_pkg::ID_W-1:0]        in_key_id;
  logic [dvpd_pkg::ID_W-1:0]        in_feature_id;
  logic                             in_new_call;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [dvpd_pkg::FRAME_W-1:0]     out_clear_bits;
  logic [1:0]                       out_cipher_used;
  logic                             out_encrypted;
  logic                             out_play;

  // predictor copy of config and per-slot key state
  logic [7:0]   reg_basic = 8'h00;
  logic [39:0]  reg_enh = 40'h0;
  logic         reg_mute [2] = '{1'b1, 1'b1};
  logic [47:0]  slot_key [2] = '{48'h0, 48'h0};
  logic         slot_key_valid [2] = '{1'b0, 1'b0};

  dvpd_pkg::result_t want_frames [$];
  int mismatches = 0;
  int cycle_count = 0;
  int hold = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  dmr_voice_privacy_descrambler_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_slot         (in_slot),
    .in_voice_bits   (in_voice_bits),
    .in_privacy_flag (in_privacy_flag),
    .in_key_id       (in_key_id),
    .in_feature_id   (in_feature_id),
    .in_new_call     (in_new_call),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clear_bits  (out_clear_bits),
    .out_cipher_used (out_cipher_used),
    .out_encrypted   (out_encrypted),
    .out_play        (out_play)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, want_frames.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // frame bit j takes key bit 47-j
  function automatic logic [47:0] mirror48(input logic [47:0] k);
    logic [47:0] m;
    for (int j = 0; j < 48; j++) begin
      m[j] = k[47-j];
    end
    return m;
  endfunction

  function automatic dvpd_pkg::result_t descramble_frame(input dvpd_pkg::item_t it);
    dvpd_pkg::result_t r;
    logic [15:0] e;
    logic [63:0] k;
    logic [63:0] t;
    logic gate;
    gate = it.privacy_flag && it.key_id == 8'h00;
    r.clear_bits = it.voice_bits;
    r.cipher = dvpd_pkg::CIPHER_NONE;
    if (gate && it.feature_id == dvpd_pkg::FID_BASIC && reg_basic != 8'h00) begin
      e = PRIVACY_ROM[reg_basic];
      k = (64'(e & 16'hFF0F) << 32) | (64'(e) << 16) | 64'(e);
      r.clear_bits ^= {1'b0, mirror48(k[47:0])};
      r.cipher = dvpd_pkg::CIPHER_BASIC;
    end else if (gate && it.feature_id == dvpd_pkg::FID_ENH && reg_enh != 40'h0) begin
      if (it.new_call || !slot_key_valid[it.slot]) begin
        k = 64'(reg_enh) << 8;
        k |= (k >> 40) & 64'hFF;
        slot_key[it.slot] = k[47:0];
        slot_key_valid[it.slot] = 1'b1;
      end
      k = 64'(slot_key[it.slot]);
      r.clear_bits ^= {1'b0, mirror48(k[47:0])};
      t = k << 1;
      k = ((t << 8) & 64'hFFFF_FFFF_0000) | ((t >> 32) & 64'hFFFF);
      slot_key[it.slot] = k[47:0];
      r.cipher = dvpd_pkg::CIPHER_ENH;
    end
    r.encrypted = it.privacy_flag;
    r.play = !it.privacy_flag || !reg_mute[it.slot];
    return r;
  endfunction

  // cfg_we is left high; the next frame transfer lowers it
  task automatic write_reg(input logic [dvpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dvpd_pkg::CFG_BASIC_KEY:    reg_basic = val[7:0];
      dvpd_pkg::CFG_ENHANCED_KEY: reg_enh = val;
      dvpd_pkg::CFG_MUTE_SLOT0:   reg_mute[0] = val[0];
      dvpd_pkg::CFG_MUTE_SLOT1:   reg_mute[1] = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (want_frames.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input dvpd_pkg::item_t it, input bit fixed_ok,
                            input dvpd_pkg::result_t fixed);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    if (cfg_we) cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_slot <= it.slot;
    in_voice_bits <= it.voice_bits;
    in_privacy_flag <= it.privacy_flag;
    in_key_id <= it.key_id;
    in_feature_id <= it.feature_id;
    in_new_call <= it.new_call;
    do @(posedge clk); while (in_stall !== 1'b0);
    want_frames.push_back(fixed_ok ? fixed : descramble_frame(it));
  endtask

  always @(posedge clk) begin : rx_side
    dvpd_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (want_frames.size() == 0) begin
        $display("%0t: result with nothing pending, clear_bits %h", $time, out_clear_bits);
        mismatches++;
      end else begin
        want = want_frames.pop_front();
        if (out_clear_bits !== want.clear_bits) begin
          $display("%0t: clear_bits expected %h got %h", $time, want.clear_bits,
                   out_clear_bits);
          mismatches++;
        end
        if (out_cipher_used !== want.cipher) begin
          $display("%0t: cipher_used expected %0d got %0d", $time, want.cipher,
                   out_cipher_used);
          mismatches++;
        end
        if (out_encrypted !== want.encrypted) begin
          $display("%0t: encrypted expected %b got %b", $time, want.encrypted,
                   out_encrypted);
          mismatches++;
        end
        if (out_play !== want.play) begin
          $display("%0t: play expected %b got %b", $time, want.play, out_play);
          mismatches++;
        end
      end
      hold = rx_calm ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
    end else if (hold != 0) begin
      hold--;
    end
    out_stall <= (hold != 0);
  end

  initial begin
    row_t row;
    dvpd_pkg::item_t it;
    dvpd_pkg::item_t call_tmpl [2];
    bit call_live [2];
    int pick;
    logic s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_slot = 1'b0;
    in_voice_bits = '0;
    in_privacy_flag = 1'b0;
    in_key_id = '0;
    in_feature_id = '0;
    in_new_call = 1'b0;
    call_live = '{1'b0, 1'b0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.data[39:0]);
      end else begin
        it.slot = row.slot;
        it.voice_bits = row.data;
        it.privacy_flag = row.priv;
        it.key_id = row.key_id;
        it.feature_id = row.feat_id;
        it.new_call = row.new_call;
        send_frame(it, row.kind == ROW_FIXED, '{row.data, row.x_cipher, row.priv, row.x_play});
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // every phase boundary drains the block before touching config
      wait_idle();
      if (phase == 0) begin
        write_reg(dvpd_pkg::CFG_BASIC_KEY, 40'hFF);
        write_reg(dvpd_pkg::CFG_ENHANCED_KEY, EKEY_MAX);
      end else if (phase == 1) begin
        write_reg(dvpd_pkg::CFG_BASIC_KEY, 40'h1);
        write_reg(dvpd_pkg::CFG_ENHANCED_KEY, 40'h1);
      end else begin
        write_reg(dvpd_pkg::CFG_BASIC_KEY,
                  ($urandom_range(0, 9) == 0) ? 40'h0 : 40'($urandom_range(1, 255)));
        write_reg(dvpd_pkg::CFG_ENHANCED_KEY,
                  ($urandom_range(0, 9) == 0) ? 40'h0 : 40'({$urandom, $urandom}));
      end
      write_reg(dvpd_pkg::CFG_MUTE_SLOT0, 40'($urandom_range(0, 1)));
      write_reg(dvpd_pkg::CFG_MUTE_SLOT1, 40'($urandom_range(0, 1)));
      write_reg(8'($urandom_range(dvpd_pkg::CFG_MUTE_SLOT1 + 1, 255)),
                40'({$urandom, $urandom}));

      for (int n = 0; n < PHASE_FRAMES; n++) begin
        s = 1'($urandom_range(0, 1));
        if (!call_live[s] || $urandom_range(0, 15) == 0) begin
          pick = $urandom_range(0, 99);
          call_tmpl[s].privacy_flag = 1'b1;
          call_tmpl[s].key_id = 8'h00;
          if (pick < 40) begin
            call_tmpl[s].feature_id = dvpd_pkg::FID_ENH;
          end else if (pick < 70) begin
            call_tmpl[s].feature_id = dvpd_pkg::FID_BASIC;
          end else if (pick < 80) begin
            call_tmpl[s].privacy_flag = 1'b0;
            call_tmpl[s].key_id = 8'($urandom);
            call_tmpl[s].feature_id = 8'($urandom);
          end else begin
            // noisy call header
            call_tmpl[s].privacy_flag = 1'($urandom_range(0, 1));
            call_tmpl[s].key_id = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
            pick = $urandom_range(0, 2);
            call_tmpl[s].feature_id = (pick == 0) ? dvpd_pkg::FID_BASIC :
                                      (pick == 1) ? dvpd_pkg::FID_ENH : 8'($urandom);
          end
          call_live[s] = 1'b1;
          it = call_tmpl[s];
          it.new_call = 1'b1;
        end else begin
          it = call_tmpl[s];
          it.new_call = ($urandom_range(0, 31) == 0);
          if ($urandom_range(0, 49) == 0) it.key_id = 8'($urandom);
        end
        it.slot = s;
        pick = $urandom_range(0, 19);
        it.voice_bits = (pick == 0) ? 49'h0 : (pick == 1) ? ALL_ONES : 49'({$urandom, $urandom});
        send_frame(it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== dmr_voice_privacy_descrambler_unit.f =====
hdl/dvpd_pkg.sv
hdl/dvpd_core.sv
hdl/dmr_voice_privacy_descrambler_unit.sv
tb/dmr_voice_privacy_descrambler_unit_tb.sv
